// ----- design/sfs_pkg.sv -----
// Shared types, constants and sequencer states of the spectral floor split block.
// No dependencies; every other design file imports this package.
package sfs_pkg;

  typedef logic [9:0]         bin_t;
  typedef logic signed [23:0] mag_t;
  typedef logic [22:0]        excess_t;
  typedef logic [3:0]         win_t;

  localparam mag_t    MAG_MAX    = 24'sh7FFFFF;
  localparam excess_t EXCESS_MAX = 23'h7FFFFF;
  localparam win_t    WIN_RESET  = 4'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LAST,
    ST_DONE
  } sfs_state_t;

  typedef struct packed {
    logic load;
    logic cmp;
  } min_ctl_t;

endpackage

// ----- design/sfs_if.sv -----
// Valid/ready channel interfaces for magnitude items and floor results.
// Depends on sfs_pkg for payload types.
interface sfs_in_if;
  import sfs_pkg::*;
  logic valid;
  logic ready;
  bin_t bin_index;
  mag_t magnitude;
  modport source (output valid, output bin_index, output magnitude, input ready);
  modport sink (input valid, input bin_index, input magnitude, output ready);
endinterface

interface sfs_out_if;
  import sfs_pkg::*;
  logic    valid;
  logic    ready;
  mag_t    floor_value;
  excess_t tonal_excess;
  modport source (output valid, output floor_value, output tonal_excess, input ready);
  modport sink (input valid, input floor_value, input tonal_excess, output ready);
endinterface

// ----- design/sfs_hist_mem.sv -----
// Single-write, single-read history memory with registered read data.
// Depends on sfs_pkg for the entry type.
module sfs_hist_mem #(
  parameter int DEPTH  = 9216,
  parameter int ADDR_W = 14
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  sfs_pkg::mag_t     wdata,
  input  logic [ADDR_W-1:0] raddr,
  output sfs_pkg::mag_t     rdata
);
  import sfs_pkg::*;

  mag_t mem [DEPTH];
  mag_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/sfs_min_unit.sv -----
// Shared compare unit: running minimum and saturated excess of the current item.
// Depends on sfs_pkg for types and the excess limit.
module sfs_min_unit (
  input  logic              clk,
  input  sfs_pkg::min_ctl_t ctl,
  input  sfs_pkg::mag_t     load_mag,
  input  sfs_pkg::mag_t     cmp_data,
  input  sfs_pkg::mag_t     cur_mag,
  output sfs_pkg::mag_t     floor_value,
  output sfs_pkg::excess_t  tonal_excess
);
  import sfs_pkg::*;

  mag_t              min_r;
  logic signed [24:0] diff;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      min_r <= load_mag;
    end else if (ctl.cmp && (cmp_data < min_r)) begin
      min_r <= cmp_data;
    end
  end

  assign diff = {cur_mag[23], cur_mag} - {min_r[23], min_r};

  always_comb begin
    priority if (diff[24]) begin
      tonal_excess = '0;
    end else if (diff[23]) begin
      tonal_excess = EXCESS_MAX;
    end else begin
      tonal_excess = diff[22:0];
    end
  end

  assign floor_value = min_r;

endmodule

// ----- design/sfs_ctrl.sv -----
// Sequencer: clearing pass, history sweep with shift write-back, result hand-off.
// Depends on sfs_pkg for states, types and the reset fill value.
module sfs_ctrl #(
  parameter int BIN_COUNT      = 1024,
  parameter int HISTORY_FRAMES = 10,
  parameter int ADDR_W         = 14
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  sfs_pkg::bin_t     in_bin,
  input  sfs_pkg::mag_t     in_mag,
  output logic              in_ready,
  input  sfs_pkg::win_t     window_length,
  input  logic              out_busy,
  output logic              out_load,
  output logic              mem_we,
  output logic [ADDR_W-1:0] mem_waddr,
  output sfs_pkg::mag_t     mem_wdata,
  output logic [ADDR_W-1:0] mem_raddr,
  input  sfs_pkg::mag_t     mem_rdata,
  output sfs_pkg::min_ctl_t min_ctl,
  output sfs_pkg::mag_t     cur_mag
);
  import sfs_pkg::*;

  localparam int HIST_DEPTH = HISTORY_FRAMES - 1;
  localparam int MEM_DEPTH  = BIN_COUNT * HIST_DEPTH;
  localparam int K_W        = $clog2(HISTORY_FRAMES);
  localparam int WIN_W      = 6;

  sfs_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [ADDR_W-1:0] base_r;
  logic [K_W-1:0]    rd_k_r;
  logic [K_W-1:0]    dk_r;
  logic [K_W-1:0]    thresh_r, thresh_nxt;
  logic              dvld_r;
  logic              inrange_r;
  mag_t              mag_r;
  logic              in_fire;
  logic              in_range;
  logic [WIN_W-1:0]  win_eff;

  assign in_fire  = in_ready && in_valid;
  assign in_range = ({22'd0, in_bin} < 32'(BIN_COUNT));

  always_comb begin
    win_eff = {2'b00, window_length};
    priority if (win_eff == '0) begin
      win_eff = WIN_W'(1);
    end else if (win_eff > WIN_W'(HISTORY_FRAMES)) begin
      win_eff = WIN_W'(HISTORY_FRAMES);
    end else begin
      win_eff = win_eff;
    end
    thresh_nxt = K_W'(WIN_W'(HISTORY_FRAMES) - win_eff);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == ADDR_W'(MEM_DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = in_range ? ST_READ : ST_DONE;
      end
      ST_READ: begin
        if (rd_k_r == K_W'(HIST_DEPTH - 1)) state_nxt = ST_LAST;
      end
      ST_LAST: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready    = (state_r == ST_IDLE);
    out_load    = (state_r == ST_DONE) && !out_busy;
    min_ctl     = '{load: in_fire, cmp: dvld_r && (dk_r >= thresh_r)};
    mem_raddr   = base_r + ADDR_W'(rd_k_r);
    mem_we      = 1'b0;
    mem_waddr   = base_r + ADDR_W'(dk_r) - ADDR_W'(1);
    mem_wdata   = mem_rdata;
    priority if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = MAG_MAX;
    end else if (dvld_r && (dk_r != '0)) begin
      mem_we    = 1'b1;
    end else if ((state_r == ST_DONE) && inrange_r) begin
      mem_we    = 1'b1;
      mem_waddr = base_r + ADDR_W'(HIST_DEPTH - 1);
      mem_wdata = mag_r;
    end else begin
      mem_we    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      dvld_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dvld_r  <= (state_r == ST_READ);
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    dk_r <= rd_k_r;
    if (in_fire) begin
      mag_r     <= in_mag;
      inrange_r <= in_range;
      thresh_r  <= thresh_nxt;
      base_r    <= ADDR_W'(32'(in_bin) * 32'(HIST_DEPTH));
      rd_k_r    <= '0;
    end else if (state_r == ST_READ) begin
      rd_k_r <= rd_k_r + K_W'(1);
    end
  end

  assign cur_mag = mag_r;

endmodule

// ----- design/spectral_floor_split.sv -----
// Top level of the spectral floor split block: per-bin sliding-window minimum.
// Depends on sfs_pkg, sfs_if, sfs_ctrl, sfs_min_unit and sfs_hist_mem.
//
// Usage:
//   in_ch carries one magnitude per transfer, tagged with its frequency bin.
//   out_ch returns one result per input: the window floor and the excess of
//   the magnitude over it. cfg_wr_en/cfg_wr_data set window_length (reset 3);
//   write it only while the block is idle.
// Reset: history entries are filled with the largest positive value by a
//   clearing pass over all BIN_COUNT*(HISTORY_FRAMES-1) entries (9216 at
//   defaults), during which in_ch.ready stays low.
// Sequencing: for a bin in range the controller sweeps the bin's stored
//   frames through the single memory read port (ST_READ), then passes
//   ST_LAST and enters ST_DONE, where the result is loaded into the output
//   register. in_ch.ready is high only in ST_IDLE, so the next input is
//   taken only after the previous result is loaded. A bin out of range
//   bypasses the memory and goes straight to ST_DONE.
// Stall: the output register holds a result until out_ch.ready; the next
//   item is still taken and swept, then waits for the register to free.
module spectral_floor_split #(
  parameter int BIN_COUNT      = 1024,
  parameter int HISTORY_FRAMES = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  sfs_in_if.sink        in_ch,
  sfs_out_if.source     out_ch,
  input  logic          cfg_wr_en,
  input  sfs_pkg::win_t cfg_wr_data
);
  import sfs_pkg::*;

  localparam int MEM_DEPTH = BIN_COUNT * (HISTORY_FRAMES - 1);
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  win_t              window_length_r;
  logic              out_valid_r;
  mag_t              out_floor_r;
  excess_t           out_excess_r;
  logic              out_load;
  logic              out_busy;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  mag_t              mem_wdata;
  mag_t              mem_rdata;
  min_ctl_t          min_ctl;
  mag_t              cur_mag;
  mag_t              floor_value;
  excess_t           tonal_excess;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= WIN_RESET;
    end else if (cfg_wr_en) begin
      window_length_r <= cfg_wr_data;
    end
  end

  assign out_busy = out_valid_r && !out_ch.ready;

  sfs_ctrl #(
    .BIN_COUNT      (BIN_COUNT),
    .HISTORY_FRAMES (HISTORY_FRAMES),
    .ADDR_W         (ADDR_W)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_bin        (in_ch.bin_index),
    .in_mag        (in_ch.magnitude),
    .in_ready      (in_ch.ready),
    .window_length (window_length_r),
    .out_busy      (out_busy),
    .out_load      (out_load),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata),
    .min_ctl       (min_ctl),
    .cur_mag       (cur_mag)
  );

  sfs_min_unit u_min (
    .clk          (clk),
    .ctl          (min_ctl),
    .load_mag     (in_ch.magnitude),
    .cmp_data     (mem_rdata),
    .cur_mag      (cur_mag),
    .floor_value  (floor_value),
    .tonal_excess (tonal_excess)
  );

  sfs_hist_mem #(
    .DEPTH  (MEM_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_floor_r  <= floor_value;
      out_excess_r <= tonal_excess;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.floor_value  = out_floor_r;
  assign out_ch.tonal_excess = out_excess_r;

endmodule

// ----- design/sfs_checker.sv -----
// Port-level checks of the spectral floor split block, bound to its top level.
// Depends on sfs_pkg for payload types and on spectral_floor_split.
module sfs_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input sfs_pkg::mag_t    out_floor,
  input sfs_pkg::excess_t out_excess
);
  import sfs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_floor) && $stable(out_excess))
    else $error("result changed while stalled");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again without working on the previous item");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared one cycle after transfer");

  a_clear_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> !in_ready && !out_valid)
    else $error("input taken or result shown before history clear");

endmodule

bind spectral_floor_split sfs_checker u_sfs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_floor  (out_ch.floor_value),
  .out_excess (out_ch.tonal_excess)
);

// ----- verif/tb_top.sv -----
// Testbench for spectral_floor_split: directed table, then random phases with per-bin predictor.
// Depends on sfs_pkg and the sfs_in_if / sfs_out_if channel interfaces of the design.
module tb_top;
  import sfs_pkg::*;

  localparam int   NUM_BINS    = 1024;
  localparam int   HIST_FRAMES = 10;
  localparam int   HIST_DEPTH  = HIST_FRAMES - 1;
  localparam int   SETTLE      = HIST_FRAMES + 4;
  localparam int   HOLD_CYCLES = 400;
  localparam int   IDLE_LIMIT  = 40000;
  localparam int   NUM_PHASES  = 9;
  localparam int   PHASE_ITEMS = 148;
  localparam mag_t MAG_MIN     = 24'sh800000;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    mag_t    floor_value;
    excess_t tonal_excess;
  } floor_res_t;

  typedef struct packed {
    row_kind_t kind;
    win_t      win;
    bin_t      bin;
    mag_t      mag;
    logic      known;
    mag_t      floor_value;
    excess_t   tonal_excess;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  win_t cfg_wr_data;

  sfs_in_if  in_ch ();
  sfs_out_if out_ch ();

  spectral_floor_split uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  mag_t       bin_hist [NUM_BINS][HIST_DEPTH];
  win_t       win_cfg;
  floor_res_t floor_expect_q [$];
  int         fail_count = 0;
  bit         tx_calm = 0;
  bit         rx_calm = 0;
  bit         hold_req = 0;

  dir_row_t dir_rows [26] = '{
    '{ROW_ITEM, 4'd0,  10'h000, 24'sd327680, 1'b1, 24'sd327680, 23'd0},
    '{ROW_ITEM, 4'd0,  10'h3FF, MAG_MIN,     1'b1, MAG_MIN,     23'd0},
    '{ROW_ITEM, 4'd0,  10'h3FF, MAG_MAX,     1'b1, MAG_MIN,     EXCESS_MAX},
    '{ROW_ITEM, 4'd0,  10'h3FF, 24'sd0,      1'b1, MAG_MIN,     EXCESS_MAX},
    '{ROW_ITEM, 4'd0,  10'h3FF, 24'sd100,    1'b1, 24'sd0,      23'd100},
    '{ROW_ITEM, 4'd0,  10'h000, MAG_MAX,     1'b1, 24'sd327680, 23'd8060927},
    '{ROW_ITEM, 4'd0,  10'h2AA, 24'sh555555, 1'b1, 24'sh555555, 23'd0},
    '{ROW_ITEM, 4'd0,  10'h155, 24'shAAAAAA, 1'b1, 24'shAAAAAA, 23'd0},
    '{ROW_ITEM, 4'd0,  10'h2AA, 24'sd1000,   1'b0, 24'sd0,      23'd0},
    '{ROW_ITEM, 4'd0,  10'h2AA, -24'sd1,     1'b0, 24'sd0,      23'd0},
    '{ROW_ITEM, 4'd0,  10'h2AA, 24'sd2000,   1'b0, 24'sd0,      23'd0},
    '{ROW_CFG,  4'd0,  10'h000, 24'sd0,      1'b0, 24'sd0,      23'd0},
    '{ROW_ITEM, 4'd0,  10'h3FF, 24'sd77,     1'b1, 24'sd77,     23'd0},
    '{ROW_ITEM, 4'd0,  10'h2AA, -24'sd2,     1'b1, -24'sd2,     23'd0},
    '{ROW_CFG,  4'd15, 10'h000, 24'sd0,      1'b0, 24'sd0,      23'd0},
    '{ROW_ITEM, 4'd0,  10'h3FF, 24'sd5000,   1'b0, 24'sd0,      23'd0},
    '{ROW_ITEM, 4'd0,  10'h2AA, 24'sd3,      1'b0, 24'sd0,      23'd0},
    '{ROW_CFG,  4'd10, 10'h000, 24'sd0,      1'b0, 24'sd0,      23'd0},
    '{ROW_ITEM, 4'd0,  10'h2AA, 24'sd4,      1'b0, 24'sd0,      23'd0},
    '{ROW_ITEM, 4'd0,  10'h3FF, MAG_MIN,     1'b0, 24'sd0,      23'd0},
    '{ROW_CFG,  4'd1,  10'h000, 24'sd0,      1'b0, 24'sd0,      23'd0},
    '{ROW_ITEM, 4'd0,  10'h000, -24'sd100,   1'b1, -24'sd100,   23'd0},
    '{ROW_ITEM, 4'd0,  10'h3FF, MAG_MAX,     1'b1, MAG_MAX,     23'd0},
    '{ROW_CFG,  4'd2,  10'h000, 24'sd0,      1'b0, 24'sd0,      23'd0},
    '{ROW_ITEM, 4'd0,  10'h155, MAG_MAX,     1'b0, 24'sd0,      23'd0},
    '{ROW_ITEM, 4'd0,  10'h000, MAG_MIN,     1'b0, 24'sd0,      23'd0}
  };

  win_t phase_win [NUM_PHASES] = '{4'd3, 4'd10, 4'd1, 4'd15, 4'd0, 4'd9, 4'd2, 4'd6, 4'd3};

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int draw_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic floor_res_t predict_floor(input bin_t b, input mag_t m);
    floor_res_t res;
    mag_t       lo;
    int         span;
    longint     diff;
    span = (win_cfg == 0) ? 1 : (win_cfg > HIST_FRAMES) ? HIST_FRAMES : int'(win_cfg);
    lo = m;
    for (int k = 0; k < span - 1; k++)
      if (bin_hist[b][HIST_DEPTH-1-k] < lo) lo = bin_hist[b][HIST_DEPTH-1-k];
    for (int k = 0; k < HIST_DEPTH - 1; k++)
      bin_hist[b][k] = bin_hist[b][k+1];
    bin_hist[b][HIST_DEPTH-1] = m;
    diff = longint'(m) - longint'(lo);
    if (diff < 0) diff = 0;
    if (diff > longint'(EXCESS_MAX)) diff = longint'(EXCESS_MAX);
    res.floor_value  = lo;
    res.tonal_excess = excess_t'(diff);
    return res;
  endfunction

  function automatic mag_t draw_mag(input mag_t base);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0: return MAG_MAX;
        1: return MAG_MIN;
        2: return 24'sd0;
        default: return -24'sd1;
      endcase
    end
    if (r < 20) return mag_t'($urandom);
    return mag_t'(base + $signed($urandom_range(0, 4000)) - 2000);
  endfunction

  task automatic send_mag(input bin_t b, input mag_t m, input logic known,
                          input mag_t kf, input excess_t ke);
    floor_res_t want;
    int         gap;
    in_ch.valid     <= 1'b1;
    in_ch.bin_index <= b;
    in_ch.magnitude <= m;
    do @(posedge clk); while (!in_ch.ready);
    want = predict_floor(b, m);
    if (known) begin
      want.floor_value  = kf;
      want.tonal_excess = ke;
    end
    floor_expect_q.push_back(want);
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained(input int settle);
    in_ch.valid <= 1'b0;
    while (floor_expect_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_window(input win_t w);
    wait_drained(SETTLE);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    win_cfg = w;
  endtask

  task automatic check_result();
    floor_res_t want;
    if (floor_expect_q.size() == 0) begin
      $error("unexpected result: floor_value %0d tonal_excess %0d",
             out_ch.floor_value, out_ch.tonal_excess);
      fail_count++;
    end else begin
      want = floor_expect_q.pop_front();
      if (out_ch.floor_value !== want.floor_value) begin
        $error("floor_value: expected %0d, actual %0d", want.floor_value, out_ch.floor_value);
        fail_count++;
      end
      if (out_ch.tonal_excess !== want.tonal_excess) begin
        $error("tonal_excess: expected %0d, actual %0d", want.tonal_excess,
               out_ch.tonal_excess);
        fail_count++;
      end
    end
  endtask

  initial begin
    int off_left;
    off_left = 0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) check_result();
      if (hold_req) begin
        off_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (off_left > 0) begin
        out_ch.ready <= 1'b0;
        off_left--;
      end else if (rx_calm || $urandom_range(0, 2) != 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        off_left = draw_gap(1'b0);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    bin_t pool [6];
    mag_t base;
    bin_t b;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.bin_index = '0;
    in_ch.magnitude = '0;
    out_ch.ready    = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    win_cfg         = WIN_RESET;
    foreach (bin_hist[i, j]) bin_hist[i][j] = MAG_MAX;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        write_window(dir_rows[i].win);
      else
        send_mag(dir_rows[i].bin, dir_rows[i].mag, dir_rows[i].known,
                 dir_rows[i].floor_value, dir_rows[i].tonal_excess);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 1) phase_win[p] = win_t'($urandom_range(0, 15));
      write_window(phase_win[p]);
      foreach (pool[j]) pool[j] = bin_t'($urandom);
      base    = mag_t'($urandom);
      tx_calm = (p == 1) || (p == 3);
      rx_calm = (p == 3);
      if (p == 1) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 5 && n == PHASE_ITEMS / 2) wait_drained(0);
        if (p == 1 && n == 40) tx_calm = 1'b0;
        b = ($urandom_range(0, 9) == 0) ? bin_t'($urandom) : pool[$urandom_range(0, 5)];
        send_mag(b, draw_mag(base), 1'b0, 24'sd0, 23'd0);
      end
    end

    wait_drained(SETTLE);
    if (fail_count == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/sfs_pkg.sv
design/sfs_if.sv
design/sfs_hist_mem.sv
design/sfs_min_unit.sv
design/sfs_ctrl.sv
design/spectral_floor_split.sv
design/sfs_checker.sv
verif/tb_top.sv
